>>> hw/rtl/canonical_kmer_context_extractor_macros.svh
// assertion macros for the canonical k-mer context extractor
// used by the top level only; expects aclk and aresetn in scope
`ifndef CANONICAL_KMER_CONTEXT_EXTRACTOR_MACROS_SVH
`define CANONICAL_KMER_CONTEXT_EXTRACTOR_MACROS_SVH

// a condition that must hold at every clock edge out of reset
`define CKCE_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// a condition that must hold whenever its trigger holds
`define CKCE_ASSERT_IMPLY(name, trig, expr, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (expr)) \
        else $error(msg);

`endif

>>> hw/rtl/ckce_pkg.sv
// shared types and constants of the canonical k-mer context extractor
// no dependencies
`default_nettype none

package ckce_pkg;

    localparam int KMER_W = 42;
    localparam int ID_W   = 32;
    localparam int LEN_W  = 8;
    localparam int CTX_W  = 5;

    localparam logic [CTX_W-1:0] CTX_NONE = 5'd16;

    // one location record
    typedef struct packed {
        logic [KMER_W-1:0] canon_kmer;
        logic [ID_W-1:0]   read_id;
        logic [LEN_W-1:0]  offset;
        logic [LEN_W-1:0]  read_len;
        logic [CTX_W-1:0]  ctx;
        logic              rev;
        logic              last;
    } kmer_rec_t;

    // context of the reverse complement: swap prefix and suffix, complement both
    function automatic logic [CTX_W-1:0] ctx_rc_map(input logic [CTX_W-1:0] ctx);
        logic [CTX_W-1:0] mapped;
        if (ctx[4]) begin
            mapped = CTX_NONE;
        end else begin
            mapped = {1'b0, ~ctx[1:0], ~ctx[3:2]};
        end
        return mapped;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/canonical_kmer_context_extractor.sv
// canonical k-mer context extractor, top level
// depends on ckce_pkg and canonical_kmer_context_extractor_macros.svh
//
// Bases of a DNA read enter on the s_ channel, one 2-bit base per transaction,
// with the read id, the read length and a first_base mark. A KMER_LEN-base
// window slides along the read; each full window leaves on the m_ channel as
// one location record carrying the canonical k-mer, offset, read length, the
// reversed flag and a context code. A window goes out when the base after it
// arrives; the read's final base releases up to two records, the second of
// which carries last_of_run high. Reads shorter than KMER_LEN give nothing.
// A record enters the pair stage when its base is accepted and then moves on
// to the output register, which drives m_.
// Throughput: one base per cycle while each base yields at most one record and
// m_ready keeps up; a base that yields two records holds s_ready low while the
// single output register drains the two-record pair stage.
// Reset clears the windows, the read position and every valid flag.
// When the receiver stalls the output register and the pair stage fill and
// s_ready drops; nothing is lost and state advances only on accepted bases.
`default_nettype none

module canonical_kmer_context_extractor #(
    parameter int KMER_LEN = 21
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    // base stream
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [1:0]                  s_base,
    input  wire logic [ckce_pkg::ID_W-1:0]   s_read_id,
    input  wire logic [ckce_pkg::LEN_W-1:0]  s_read_len,
    input  wire logic                        s_first_base,
    // location records
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [ckce_pkg::KMER_W-1:0]      m_canon_kmer,
    output logic [ckce_pkg::ID_W-1:0]        m_loc_read_id,
    output logic [ckce_pkg::LEN_W-1:0]       m_loc_offset,
    output logic [ckce_pkg::LEN_W-1:0]       m_loc_read_len,
    output logic [ckce_pkg::CTX_W-1:0]       m_context_code,
    output logic                             m_was_reversed,
    output logic                             m_last_of_run
);

    import ckce_pkg::*;

`include "canonical_kmer_context_extractor_macros.svh"

    localparam int WIN_W = 2 * KMER_LEN;
    localparam int EXT_W = (WIN_W > KMER_W) ? WIN_W : KMER_W;
    localparam logic [LEN_W:0] KLEN = (LEN_W + 1)'(KMER_LEN);
    localparam logic [LEN_W-1:0] POS_MAX = {LEN_W{1'b1}};

    // sliding window state
    logic [WIN_W-1:0] fw_reg, fw_next;
    logic [WIN_W-1:0] rc_reg, rc_next;
    logic [1:0]       drop_reg, drop_next;
    logic [LEN_W-1:0] pos_reg, pos_next;

    // pair stage and output register
    kmer_rec_t pa_reg, pa_next;
    kmer_rec_t pb_reg, pb_next;
    logic      pa_vld_reg, pa_vld_next;
    logic      pb_vld_reg, pb_vld_next;
    kmer_rec_t out_reg, out_next;
    logic      out_vld_reg, out_vld_next;

    logic             in_fire;
    logic             out_load;
    logic             pair_free;
    logic [WIN_W-1:0] fw_cur, rc_cur;
    logic [1:0]       drop_cur;
    logic [LEN_W-1:0] p;
    logic [LEN_W:0]   p_ext, p_inc;
    logic             emit_a, emit_b;
    logic [LEN_W-1:0] off_a, off_b;
    logic [CTX_W-1:0] ctx_a;
    kmer_rec_t        rec_a, rec_b;

    // build one record from a window pair
    function automatic kmer_rec_t build_rec(
        input logic [WIN_W-1:0] fw,
        input logic [WIN_W-1:0] rc,
        input logic [ID_W-1:0]  rid,
        input logic [LEN_W-1:0] off,
        input logic [LEN_W-1:0] len,
        input logic [CTX_W-1:0] ctx,
        input logic             last
    );
        kmer_rec_t  r;
        logic       rev;
        logic [EXT_W-1:0] canon_ext;
        rev = (rc < fw);
        canon_ext = EXT_W'(rev ? rc : fw);
        r.canon_kmer = canon_ext[KMER_W-1:0];
        r.read_id    = rid;
        r.offset     = off;
        r.read_len   = len;
        r.ctx        = rev ? ctx_rc_map(ctx) : ctx;
        r.rev        = rev;
        r.last       = last;
        return r;
    endfunction

    // handshake
    assign out_load  = !out_vld_reg || m_ready;
    assign pair_free = !(pa_vld_reg || pb_vld_reg) ||
                       (out_load && (pa_vld_reg ^ pb_vld_reg));
    assign s_ready   = pair_free;
    assign in_fire   = s_valid && s_ready;

    // window as seen by this base, cleared on the first base of a read
    assign fw_cur   = s_first_base ? '0 : fw_reg;
    assign rc_cur   = s_first_base ? '0 : rc_reg;
    assign drop_cur = s_first_base ? 2'd0 : drop_reg;
    assign p        = s_first_base ? '0 : pos_reg;
    assign p_ext    = {1'b0, p};
    assign p_inc    = p_ext + 1'b1;

    // shift the new base in
    assign fw_next   = in_fire ? {fw_cur[WIN_W-3:0], s_base} : fw_reg;
    assign rc_next   = in_fire ? {~s_base, rc_cur[WIN_W-1:2]} : rc_reg;
    assign drop_next = in_fire ? fw_cur[WIN_W-1 -: 2] : drop_reg;
    assign pos_next  = in_fire ? ((p == POS_MAX) ? POS_MAX : p_inc[LEN_W-1:0]) : pos_reg;

    // record of the window before this base, and of the read's final window
    assign emit_a = (p_ext >= KLEN) && (p < s_read_len);
    assign emit_b = (p_inc == {1'b0, s_read_len}) && (p_inc >= KLEN);
    assign off_a  = LEN_W'(p_ext - KLEN);
    assign off_b  = LEN_W'({1'b0, s_read_len} - KLEN);
    assign ctx_a  = (off_a == '0) ? CTX_NONE : {1'b0, drop_cur, s_base};

    always_comb begin
        rec_a = build_rec(fw_cur, rc_cur, s_read_id, off_a, s_read_len, ctx_a, !emit_b);
        rec_b = build_rec({fw_cur[WIN_W-3:0], s_base}, {~s_base, rc_cur[WIN_W-1:2]},
                          s_read_id, off_b, s_read_len, CTX_NONE, 1'b1);
    end

    // pair stage: load on accept, pop a first then b into the output register
    always_comb begin
        pa_next      = pa_reg;
        pb_next      = pb_reg;
        pa_vld_next  = pa_vld_reg;
        pb_vld_next  = pb_vld_reg;
        out_next     = out_reg;
        out_vld_next = out_vld_reg;
        if (out_load) begin
            out_vld_next = pa_vld_reg || pb_vld_reg;
            if (pa_vld_reg) begin
                out_next    = pa_reg;
                pa_vld_next = 1'b0;
            end else if (pb_vld_reg) begin
                out_next    = pb_reg;
                pb_vld_next = 1'b0;
            end
        end
        if (in_fire) begin
            pa_next     = rec_a;
            pb_next     = rec_b;
            pa_vld_next = emit_a;
            pb_vld_next = emit_b;
        end
    end

    // state and valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg      <= '0;
            rc_reg      <= '0;
            drop_reg    <= 2'd0;
            pos_reg     <= '0;
            pa_vld_reg  <= 1'b0;
            pb_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            fw_reg      <= fw_next;
            rc_reg      <= rc_next;
            drop_reg    <= drop_next;
            pos_reg     <= pos_next;
            pa_vld_reg  <= pa_vld_next;
            pb_vld_reg  <= pb_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // record payloads
    always_ff @(posedge aclk) begin
        pa_reg  <= pa_next;
        pb_reg  <= pb_next;
        out_reg <= out_next;
    end

    assign m_valid        = out_vld_reg;
    assign m_canon_kmer   = out_reg.canon_kmer;
    assign m_loc_read_id  = out_reg.read_id;
    assign m_loc_offset   = out_reg.offset;
    assign m_loc_read_len = out_reg.read_len;
    assign m_context_code = out_reg.ctx;
    assign m_was_reversed = out_reg.rev;
    assign m_last_of_run  = out_reg.last;

    // checks on the pair stage and the records
    `CKCE_ASSERT_IMPLY(a_notlast_has_b, m_valid && !m_last_of_run, pb_vld_reg, "final window lost behind a non-last record")
    `CKCE_ASSERT_IMPLY(a_pair_offsets, pa_vld_reg && pb_vld_reg, pb_reg.offset == pa_reg.offset + 1'b1, "pair windows not adjacent")
    `CKCE_ASSERT_IMPLY(a_ctx_range, m_valid, m_context_code <= CTX_NONE, "context code out of range")

endmodule

`default_nettype wire

>>> dv/testbench.sv
// self-checking testbench for canonical_kmer_context_extractor
// depends on ckce_pkg and the top level; it predicts every location record
// itself and compares the m_ stream with it, field by field
`timescale 1ns / 1ps

module testbench;

    import ckce_pkg::*;

    localparam int KMER       = 21;
    localparam int WIN_W      = 2 * KMER;
    localparam int HALF_CLK   = 6;
    localparam int RESET_CYC  = 10;
    localparam int DRAIN_CYC  = 12;
    localparam int STUCK_LIMIT = 2000;
    localparam int RANDOM_BASES = 1600;

    // context code of the reverse complement, indexed by the forward code
    localparam logic [CTX_W-1:0] CTX_FLIP [0:16] = '{
        5'd15, 5'd11, 5'd7, 5'd3, 5'd14, 5'd10, 5'd6, 5'd2,
        5'd13, 5'd9, 5'd5, 5'd1, 5'd12, 5'd8, 5'd4, 5'd0, 5'd16
    };

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [1:0]        s_base       = '0;
    logic [ID_W-1:0]   s_read_id    = '0;
    logic [LEN_W-1:0]  s_read_len   = '0;
    logic              s_first_base = 1'b0;

    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [KMER_W-1:0] m_canon_kmer;
    logic [ID_W-1:0]   m_loc_read_id;
    logic [LEN_W-1:0]  m_loc_offset;
    logic [LEN_W-1:0]  m_loc_read_len;
    logic [CTX_W-1:0]  m_context_code;
    logic              m_was_reversed;
    logic              m_last_of_run;

    // predictor state
    logic [WIN_W-1:0]  fwd_window  = '0;
    logic [WIN_W-1:0]  rc_window   = '0;
    logic [1:0]        left_base   = '0;
    logic [LEN_W-1:0]  next_pos    = '0;

    kmer_rec_t pending_locations[$];
    int        mismatch_count = 0;
    int        bases_sent     = 0;
    bit        tx_gaps        = 1'b0;
    bit        rx_gaps        = 1'b0;
    int        rx_stall_left  = 0;
    int        stuck_cycles   = 0;

    canonical_kmer_context_extractor #(
        .KMER_LEN(KMER)
    ) DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_base         (s_base),
        .s_read_id      (s_read_id),
        .s_read_len     (s_read_len),
        .s_first_base   (s_first_base),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_canon_kmer   (m_canon_kmer),
        .m_loc_read_id  (m_loc_read_id),
        .m_loc_offset   (m_loc_offset),
        .m_loc_read_len (m_loc_read_len),
        .m_context_code (m_context_code),
        .m_was_reversed (m_was_reversed),
        .m_last_of_run  (m_last_of_run)
    );

    always #HALF_CLK aclk = ~aclk;

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // one location record for the window held in fw / rc
    function automatic kmer_rec_t make_location(input logic [WIN_W-1:0] fw,
                                                input logic [WIN_W-1:0] rc,
                                                input logic [ID_W-1:0] id,
                                                input int offset,
                                                input logic [LEN_W-1:0] len,
                                                input logic [CTX_W-1:0] ctx);
        kmer_rec_t loc;
        logic      flip;
        flip = (rc < fw);
        loc.canon_kmer = KMER_W'(flip ? rc : fw);
        loc.read_id    = id;
        loc.offset     = LEN_W'(offset);
        loc.read_len   = len;
        loc.ctx        = flip ? CTX_FLIP[ctx] : ctx;
        loc.rev        = flip;
        loc.last       = 1'b1;
        return loc;
    endfunction

    // append one expected record at the tail of the queue
    function automatic void queue_location(input kmer_rec_t loc);
        pending_locations = {pending_locations, loc};
    endfunction

    // advance the predictor by one accepted base and queue its records
    task automatic predict_locations(input logic [1:0] b, input logic [ID_W-1:0] id,
                                     input logic [LEN_W-1:0] len, input logic first);
        int               p;
        int               n;
        logic [CTX_W-1:0] ctx;
        kmer_rec_t        loc;
        n = 0;
        if (first) begin
            p          = 0;
            fwd_window = '0;
            rc_window  = '0;
            left_base  = '0;
        end else begin
            p = next_pos;
        end

        // window before this base, with this base as its following context
        if (p >= KMER && p < len) begin
            ctx = (p == KMER) ? CTX_NONE : {1'b0, left_base, b};
            queue_location(make_location(fwd_window, rc_window, id,
                                         p - KMER, len, ctx));
            n++;
        end

        left_base  = fwd_window[WIN_W-1 -: 2];
        fwd_window = {fwd_window[WIN_W-3:0], b};
        rc_window  = {2'd3 - b, rc_window[WIN_W-1:2]};

        // final window of the read goes out with the one before it, if there is one
        if (p + 1 == len && p + 1 >= KMER) begin
            if (n > 0) begin
                loc = pending_locations.pop_back();
                loc.last = 1'b0;
                queue_location(loc);
            end
            queue_location(make_location(fwd_window, rc_window, id,
                                         len - KMER, len, CTX_NONE));
        end

        next_pos = (p < 255) ? LEN_W'(p + 1) : LEN_W'(255);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // present one base, hold it until accepted, then maybe idle
    task automatic send_base(input logic [1:0] b, input logic [ID_W-1:0] id,
                             input logic [LEN_W-1:0] len, input logic first);
        int gap;
        s_valid      <= 1'b1;
        s_base       <= b;
        s_read_id    <= id;
        s_read_len   <= len;
        s_first_base <= first;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        predict_locations(b, id, len, first);
        bases_sent++;
        gap = tx_gaps ? pick_gap() : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // a run of random bases; read_len switches to len_b from base switch_at on
    task automatic send_read(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len_a,
                             input logic [LEN_W-1:0] len_b, input int switch_at,
                             input int count, input logic mark_first);
        for (int i = 0; i < count; i++) begin
            send_base(2'($urandom_range(0, 3)), id, (i < switch_at) ? len_a : len_b,
                      mark_first && i == 0);
        end
    endtask

    // reads shorter than a window and a zero read length give nothing
    task automatic test_short_reads();
        send_read(32'd0, 8'd5, 8'd5, 5, 5, 1'b1);
        send_read(32'h8000_0001, 8'd0, 8'd0, 3, 3, 1'b1);
    endtask

    // a read of exactly one window, all T so the reverse complement wins,
    // then a read one base longer whose last base releases two records
    task automatic test_exact_window();
        for (int i = 0; i < KMER; i++) begin
            send_base(2'd3, 32'hFFFF_FFFF, 8'(KMER), i == 0);
        end
        for (int i = 0; i <= KMER; i++) begin
            send_base(2'(i % 4), 32'h0000_0000, 8'(KMER + 1), i == 0);
        end
    endtask

    // read_len changes mid-read, bases past the end, and a read without its mark
    task automatic test_read_len_change();
        send_read(32'h1234_5678, 8'd30, 8'(KMER + 1), 12, KMER + 3, 1'b1);
        send_read(32'h0F0F_0F0F, 8'(KMER + 3), 8'(KMER + 3), 3, 3, 1'b0);
    endtask

    // mostly well-formed reads with random content, some noise and broken reads
    task automatic test_random_reads();
        int               r;
        int               len;
        int               count;
        int               switch_at;
        int               len_b;
        logic             mark;
        logic [ID_W-1:0]  id;
        while (bases_sent < RANDOM_BASES) begin
            tx_gaps = ($urandom_range(0, 9) < 7);
            rx_gaps = ($urandom_range(0, 9) < 7);
            id = $urandom();
            r = $urandom_range(0, 99);
            if (r < 8) begin
                len = $urandom_range(1, KMER - 1);
            end else if (r < 86) begin
                len = $urandom_range(KMER, 48);
            end else if (r < 95) begin
                len = $urandom_range(49, 127);
            end else begin
                len = $urandom_range(200, 255);
            end
            count     = len;
            len_b     = len;
            switch_at = len;
            mark      = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 5) begin
                count = count + $urandom_range(1, 8);
            end else if (r < 9) begin
                mark = 1'b0;
            end else if (r < 13) begin
                switch_at = $urandom_range(0, len - 1);
                len_b     = $urandom_range(1, 255);
                count     = $urandom_range(1, 60);
            end else if (r < 15) begin
                len   = 0;
                len_b = 0;
                count = $urandom_range(1, 30);
            end
            send_read(id, LEN_W'(len), LEN_W'(len_b), switch_at, count, mark);
        end
    endtask

    // receiver: random stalls, comparison of every accepted record
    always @(posedge aclk) begin : check_locations
        kmer_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_locations.size() == 0) begin
                report_mismatch("record with none expected", 64'(m_canon_kmer), 64'd0);
            end else begin
                want = pending_locations.pop_front();
                if (m_canon_kmer !== want.canon_kmer)
                    report_mismatch("canon_kmer", 64'(m_canon_kmer), 64'(want.canon_kmer));
                if (m_loc_read_id !== want.read_id)
                    report_mismatch("loc_read_id", 64'(m_loc_read_id), 64'(want.read_id));
                if (m_loc_offset !== want.offset)
                    report_mismatch("loc_offset", 64'(m_loc_offset), 64'(want.offset));
                if (m_loc_read_len !== want.read_len)
                    report_mismatch("loc_read_len", 64'(m_loc_read_len), 64'(want.read_len));
                if (m_context_code !== want.ctx)
                    report_mismatch("context_code", 64'(m_context_code), 64'(want.ctx));
                if (m_was_reversed !== want.rev)
                    report_mismatch("was_reversed", 64'(m_was_reversed), 64'(want.rev));
                if (m_last_of_run !== want.last)
                    report_mismatch("last_of_run", 64'(m_last_of_run), 64'(want.last));
            end
        end
        if (rx_stall_left > 0) begin
            m_ready <= 1'b0;
            rx_stall_left--;
        end else begin
            m_ready <= 1'b1;
            rx_stall_left = rx_gaps ? pick_gap() : 0;
        end
    end

    // watchdog: too long without any transaction ends the run
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYC) @(posedge aclk);
        aresetn <= 1'b1;

        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        test_short_reads();
        test_exact_window();
        test_read_len_change();
        test_random_reads();

        // let the last records drain
        s_valid <= 1'b0;
        rx_gaps = 1'b0;
        while (pending_locations.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYC) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
